// File: hw/rtl/wdr_pkg.sv
package wdr_pkg;

	// Table geometry and field widths
	localparam int MAX_ENTRIES   = 64;
	localparam int IDX_BITS      = $clog2(MAX_ENTRIES);
	localparam int ADDR_BITS     = IDX_BITS + 1;
	localparam int COUNT_BITS    = 16;
	localparam int RANDOM_BITS   = 16;
	localparam int TOTAL_BITS    = COUNT_BITS + IDX_BITS;
	localparam int SUM_BITS      = TOTAL_BITS + 1;
	localparam int SCALE_BITS    = RANDOM_BITS + TOTAL_BITS;
	localparam int FILL_BITS     = ADDR_BITS + COUNT_BITS;
	localparam int CHOSEN_BITS   = 6;
	localparam int TOKENS_BITS   = 16;
	localparam int ENTRIES_BITS  = 7;
	localparam int CFG_DATA_BITS = 16;
	localparam int CFG_IDX_BITS  = 1;

	// Configuration register indexes
	localparam logic [CFG_IDX_BITS-1:0] REG_TOKENS  = 1'b0;
	localparam logic [CFG_IDX_BITS-1:0] REG_ENTRIES = 1'b1;

	// Register reset values
	localparam logic [TOKENS_BITS-1:0]  TOKENS_RESET  = 16'd8;
	localparam logic [ENTRIES_BITS-1:0] ENTRIES_RESET = 7'd64;

	// Request action codes
	localparam logic ACT_RESTART = 1'b0;
	localparam logic ACT_DRAW    = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RELOAD,
		ST_SCALE,
		ST_SCAN,
		ST_DECIDE
	} state_t;

	// Write request into the count table
	typedef struct packed {
		logic                  en;
		logic [IDX_BITS-1:0]   addr;
		logic [COUNT_BITS-1:0] data;
	} cnt_wr_t;

endpackage

// File: hw/rtl/wdr_count_mem.sv
module wdr_count_mem (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           clear_all,
	input  wdr_pkg::cnt_wr_t               wr,
	input  logic [wdr_pkg::IDX_BITS-1:0]   rd_addr,
	output logic [wdr_pkg::COUNT_BITS-1:0] rd_data,
	output logic                           rd_hit
);
	import wdr_pkg::*;

	logic [COUNT_BITS-1:0]  mem_q [MAX_ENTRIES];
	logic [MAX_ENTRIES-1:0] vld_q;
	logic [COUNT_BITS-1:0]  rd_data_q;
	logic                   rd_hit_q;

	// Count storage with registered read
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	// Mark entries written since the last restart; rd_hit tells the reader an entry was written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_hit_q <= 1'b0;
		end else begin
			if (clear_all) begin
				vld_q <= '0;
			end else if (wr.en) begin
				vld_q[wr.addr] <= 1'b1;
			end
			rd_hit_q <= vld_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;
	assign rd_hit  = rd_hit_q;

endmodule

// File: hw/rtl/weighted_draw_without_repeat.sv
// Channel   Handshake           Payload
// request   start / busy        action, random_fraction
// result    done (one cycle)    chosen_index, emitted, exhausted
// config    cfg_we              cfg_index, cfg_wdata
//
// A restart computes the fill total with one multiply.
// A draw passes through a scaling state, a scan of the table entries through the
// single count memory read port (up to 64 entries) and an update state.
// A draw with nothing left answers from idle in the next cycle.
// Reset empties the table at once; no clearing pass is needed.
// The receiver cannot stall: done marks each result for exactly one cycle.
module weighted_draw_without_repeat (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic                              action,
	input  logic [wdr_pkg::RANDOM_BITS-1:0]   random_fraction,
	output logic                              done,
	output logic [wdr_pkg::CHOSEN_BITS-1:0]   chosen_index,
	output logic                              emitted,
	output logic                              exhausted,
	input  logic                              cfg_we,
	input  logic [wdr_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [wdr_pkg::CFG_DATA_BITS-1:0] cfg_wdata
);
	import wdr_pkg::*;

	state_t state_q, state_d;

	logic [TOKENS_BITS-1:0]  tokens_cfg_q;
	logic [ENTRIES_BITS-1:0] entries_cfg_q;

	logic [COUNT_BITS-1:0]  load_q;
	logic [ADDR_BITS-1:0]   fill_n_q;
	logic [TOTAL_BITS-1:0]  total_q;
	logic [IDX_BITS-1:0]    last_q;
	logic                   last_vld_q;

	logic [RANDOM_BITS-1:0] frac_q;
	logic [TOTAL_BITS-1:0]  target_q;
	logic [SUM_BITS-1:0]    acc_q;
	logic [ADDR_BITS-1:0]   addr_q;
	logic                   rvalid_s1;
	logic [IDX_BITS-1:0]    idx_s1;
	logic [IDX_BITS-1:0]    chosen_q;
	logic [COUNT_BITS-1:0]  cnt_q;

	logic                   done_q;
	logic [CHOSEN_BITS-1:0] chosen_index_q;
	logic                   emitted_q;
	logic                   exhausted_q;

	logic                   accept;
	logic [ADDR_BITS-1:0]   fill_n_d;
	logic [RANDOM_BITS-1:0] mul_a;
	logic [TOTAL_BITS-1:0]  mul_b;
	logic [SCALE_BITS-1:0]  mul_prod;
	logic [FILL_BITS-1:0]   fill_prod;
	logic [TOTAL_BITS-1:0]  target_d;
	logic [COUNT_BITS-1:0]  rd_data;
	logic                   rd_hit;
	logic [COUNT_BITS-1:0]  eff_cnt;
	logic [SUM_BITS-1:0]    sum;
	logic                   hit;
	logic                   reject;
	logic                   clear_all;
	cnt_wr_t                wr;

	wdr_count_mem u_mem (
		.clk       (clk),
		.arst_n    (arst_n),
		.clear_all (clear_all),
		.wr        (wr),
		.rd_addr   (addr_q[IDX_BITS-1:0]),
		.rd_data   (rd_data),
		.rd_hit    (rd_hit)
	);

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	// Clamp the entry count to the table size
	assign fill_n_d = (entries_cfg_q > ENTRIES_BITS'(MAX_ENTRIES)) ?
		ADDR_BITS'(MAX_ENTRIES) : ADDR_BITS'(entries_cfg_q);

	// Shared multiplier: fill total on reload, target scaling otherwise
	assign mul_a     = (state_q == ST_RELOAD) ? RANDOM_BITS'(fill_n_q) : frac_q;
	assign mul_b     = (state_q == ST_RELOAD) ? TOTAL_BITS'(load_q) : total_q;
	assign mul_prod  = SCALE_BITS'(mul_a) * SCALE_BITS'(mul_b);
	assign fill_prod = mul_prod[FILL_BITS-1:0];
	assign target_d  = mul_prod[SCALE_BITS-1:RANDOM_BITS] + TOTAL_BITS'(1);

	// Untouched entries read as the restart fill value inside the filled range, else as zero
	always_comb begin
		if (rd_hit) begin
			eff_cnt = rd_data;
		end else if (ADDR_BITS'(idx_s1) < fill_n_q) begin
			eff_cnt = load_q;
		end else begin
			eff_cnt = '0;
		end
	end

	// Running sum over the scanned counts
	assign sum    = acc_q + SUM_BITS'(eff_cnt);
	assign hit    = rvalid_s1 && ((sum >= SUM_BITS'(target_q)) ||
		(idx_s1 == IDX_BITS'(MAX_ENTRIES - 1)));
	assign reject = last_vld_q && (chosen_q == last_q);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (action == ACT_RESTART) begin
						state_d = ST_RELOAD;
					end else if (total_q != '0) begin
						state_d = ST_SCALE;
					end
				end
			end
			ST_RELOAD: state_d = ST_IDLE;
			ST_SCALE:  state_d = ST_SCAN;
			ST_SCAN: begin
				if (hit) begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// Table control
	always_comb begin
		clear_all = 1'b0;
		wr.en     = 1'b0;
		wr.addr   = chosen_q;
		wr.data   = cnt_q - COUNT_BITS'(1);
		case (state_q)
			ST_RELOAD: clear_all = 1'b1;
			ST_DECIDE: wr.en = !reject && (cnt_q != '0);
			default:   wr.en = 1'b0;
		endcase
	end

	// Control state, registers and results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			tokens_cfg_q   <= TOKENS_RESET;
			entries_cfg_q  <= ENTRIES_RESET;
			load_q         <= '0;
			fill_n_q       <= '0;
			total_q        <= '0;
			last_q         <= '0;
			last_vld_q     <= 1'b0;
			rvalid_s1      <= 1'b0;
			addr_q         <= '0;
			done_q         <= 1'b0;
			chosen_index_q <= '0;
			emitted_q      <= 1'b0;
			exhausted_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= 1'b0;

			if (cfg_we) begin
				case (cfg_index)
					REG_TOKENS:  tokens_cfg_q  <= cfg_wdata[TOKENS_BITS-1:0];
					REG_ENTRIES: entries_cfg_q <= cfg_wdata[ENTRIES_BITS-1:0];
					default:     tokens_cfg_q  <= tokens_cfg_q;
				endcase
			end

			case (state_q)
				ST_IDLE: begin
					if (accept && action == ACT_RESTART) begin
						load_q   <= tokens_cfg_q[COUNT_BITS-1:0];
						fill_n_q <= fill_n_d;
					end else if (accept && total_q == '0) begin
						// nothing left to draw
						done_q         <= 1'b1;
						chosen_index_q <= '0;
						emitted_q      <= 1'b0;
						exhausted_q    <= 1'b1;
					end
				end
				ST_RELOAD: begin
					total_q        <= fill_prod[TOTAL_BITS-1:0];
					last_vld_q     <= 1'b0;
					last_q         <= '0;
					done_q         <= 1'b1;
					chosen_index_q <= '0;
					emitted_q      <= 1'b0;
					exhausted_q    <= (fill_prod == '0);
				end
				ST_SCALE: begin
					addr_q    <= '0;
					rvalid_s1 <= 1'b0;
				end
				ST_SCAN: begin
					// advance the read address until the last entry is issued
					if (!addr_q[IDX_BITS]) begin
						addr_q <= addr_q + ADDR_BITS'(1);
					end
					rvalid_s1 <= !addr_q[IDX_BITS] && !hit;
				end
				ST_DECIDE: begin
					if (!reject) begin
						if (cnt_q != '0) begin
							total_q <= total_q - TOTAL_BITS'(1);
						end
						last_q     <= chosen_q;
						last_vld_q <= 1'b1;
					end
					done_q         <= 1'b1;
					chosen_index_q <= CHOSEN_BITS'(chosen_q);
					emitted_q      <= !reject;
					exhausted_q    <= 1'b0;
				end
				default: begin
					rvalid_s1 <= 1'b0;
				end
			endcase
		end
	end

	// Draw datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			frac_q <= random_fraction;
		end
		if (state_q == ST_SCALE) begin
			target_q <= target_d;
			acc_q    <= '0;
		end
		if (state_q == ST_SCAN) begin
			idx_s1 <= addr_q[IDX_BITS-1:0];
			if (rvalid_s1) begin
				acc_q <= sum;
			end
			if (hit) begin
				chosen_q <= idx_s1;
				cnt_q    <= eff_cnt;
			end
		end
	end

	assign done         = done_q;
	assign chosen_index = chosen_index_q;
	assign emitted      = emitted_q;
	assign exhausted    = exhausted_q;

	// A result only shows once the sequencer is back at rest
	assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy)
		else $error("result shown while busy");

	// An accepted request either answers at once or keeps the block busy
	assert property (@(posedge clk) disable iff (!arst_n) accept |=> (busy || done))
		else $error("accepted request dropped");

	// An emitted entry becomes the remembered pick
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && emitted) |-> (last_vld_q && CHOSEN_BITS'(last_q) == chosen_index))
		else $error("emitted entry not recorded as last pick");

	// A scan runs only against a nonzero total
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (total_q != '0))
		else $error("scan with empty total");

	// Emitted and exhausted never show together
	assert property (@(posedge clk) disable iff (!arst_n) done |-> !(emitted && exhausted))
		else $error("emitted and exhausted both set");

endmodule

// File: dv/weighted_draw_checker.sv
module weighted_draw_checker
	import wdr_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic                     busy,
	input  logic                     action,
	input  logic [RANDOM_BITS-1:0]   random_fraction,
	input  logic                     done,
	input  logic [CHOSEN_BITS-1:0]   chosen_index,
	input  logic                     emitted,
	input  logic                     exhausted,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
	output int                       fail_count,
	output int                       pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [CHOSEN_BITS-1:0] index;
		logic                   emitted;
		logic                   exhausted;
	} outcome_t;

	// Shadow copy of the token table and registers
	logic [COUNT_BITS-1:0]   token_count [MAX_ENTRIES];
	logic [TOTAL_BITS-1:0]   tokens_left;
	logic [IDX_BITS-1:0]     prev_pick;
	logic                    prev_pick_valid;
	logic [TOKENS_BITS-1:0]  load_tokens;
	logic [ENTRIES_BITS-1:0] load_entries;

	outcome_t expected_outcomes[$];
	outcome_t predicted;
	outcome_t oldest;

	// Work out the outcome of one request and advance the shadow state
	task automatic predict_outcome(input logic act, input logic [RANDOM_BITS-1:0] frac,
			output outcome_t res);
		int                          n_load;
		logic [SCALE_BITS-1:0]       scaled;
		logic [SUM_BITS:0]           target;
		logic [SUM_BITS:0]           running;
		logic [IDX_BITS-1:0]         pick;
		bit                          found;
		res.index     = '0;
		res.emitted   = 1'b0;
		res.exhausted = 1'b0;
		if (act == ACT_RESTART) begin
			n_load = (load_entries > MAX_ENTRIES) ? MAX_ENTRIES : int'(load_entries);
			tokens_left = '0;
			for (int i = 0; i < MAX_ENTRIES; i++) begin
				token_count[i] = (i < n_load) ? load_tokens[COUNT_BITS-1:0] : '0;
				tokens_left    = tokens_left + TOTAL_BITS'(token_count[i]);
			end
			prev_pick       = '0;
			prev_pick_valid = 1'b0;
			res.exhausted   = (tokens_left == '0);
		end else if (tokens_left == '0) begin
			res.exhausted = 1'b1;
		end else begin
			scaled  = (SCALE_BITS'(frac) * SCALE_BITS'(tokens_left)) >> RANDOM_BITS;
			target  = (SUM_BITS+1)'(scaled) + 1'b1;
			running = '0;
			pick    = IDX_BITS'(MAX_ENTRIES - 1);
			found   = 1'b0;
			// Walk the cumulative counts up to the target
			for (int i = 0; i < MAX_ENTRIES; i++) begin
				running = running + (SUM_BITS+1)'(token_count[i]);
				if (!found && running >= target) begin
					pick  = IDX_BITS'(i);
					found = 1'b1;
				end
			end
			res.index = CHOSEN_BITS'(pick);
			// Drop a repeat of the previous pick
			if (!(prev_pick_valid && pick == prev_pick)) begin
				if (token_count[pick] != '0) begin
					token_count[pick] = token_count[pick] - 1'b1;
					tokens_left       = tokens_left - 1'b1;
				end
				prev_pick       = pick;
				prev_pick_valid = 1'b1;
				res.emitted     = 1'b1;
			end
		end
	endtask

	// Compare results, then predict newly accepted requests
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_ENTRIES; i++)
				token_count[i] = '0;
			tokens_left     = '0;
			prev_pick       = '0;
			prev_pick_valid = 1'b0;
			load_tokens     = TOKENS_RESET;
			load_entries    = ENTRIES_RESET;
			expected_outcomes.delete();
			fail_count      = 0;
			pending         = 0;
		end else begin
			if (done) begin
				if (expected_outcomes.size() == 0) begin
					$display("%0t: result with no request waiting: index %0d emitted %0b exhausted %0b",
						$time, chosen_index, emitted, exhausted);
					fail_count++;
				end else begin
					oldest = expected_outcomes.pop_front();
					if (chosen_index !== oldest.index) begin
						$display("%0t: chosen_index expected %0d actual %0d",
							$time, oldest.index, chosen_index);
						fail_count++;
					end
					if (emitted !== oldest.emitted) begin
						$display("%0t: emitted expected %0b actual %0b",
							$time, oldest.emitted, emitted);
						fail_count++;
					end
					if (exhausted !== oldest.exhausted) begin
						$display("%0t: exhausted expected %0b actual %0b",
							$time, oldest.exhausted, exhausted);
						fail_count++;
					end
				end
			end
			if (start && !busy) begin
				predict_outcome(action, random_fraction, predicted);
				expected_outcomes.push_back(predicted);
			end
			// Registers only take effect at the next restart
			if (cfg_we) begin
				if (cfg_index == REG_TOKENS)
					load_tokens = cfg_wdata[TOKENS_BITS-1:0];
				else if (cfg_index == REG_ENTRIES)
					load_entries = cfg_wdata[ENTRIES_BITS-1:0];
			end
			pending = expected_outcomes.size();
		end
	end

endmodule

// File: dv/weighted_draw_without_repeat_tb.sv
module weighted_draw_without_repeat_tb;
	import wdr_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_LIMIT  = 2000;
	localparam int END_LATENCY = 100;
	localparam int RAND_ITEMS  = 400;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     start = 1'b0;
	logic                     busy;
	logic                     action = ACT_RESTART;
	logic [RANDOM_BITS-1:0]   random_fraction = '0;
	logic                     done;
	logic [CHOSEN_BITS-1:0]   chosen_index;
	logic                     emitted;
	logic                     exhausted;
	logic                     cfg_we = 1'b0;
	logic [CFG_IDX_BITS-1:0]  cfg_index = REG_TOKENS;
	logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;

	int fail_count;
	int pending;
	int requests_sent = 0;
	int idle_cycles = 0;
	bit no_gaps = 1'b0;

	weighted_draw_without_repeat u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.action          (action),
		.random_fraction (random_fraction),
		.done            (done),
		.chosen_index    (chosen_index),
		.emitted         (emitted),
		.exhausted       (exhausted),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata)
	);

	weighted_draw_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.action          (action),
		.random_fraction (random_fraction),
		.done            (done),
		.chosen_index    (chosen_index),
		.emitted         (emitted),
		.exhausted       (exhausted),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata),
		.fail_count      (fail_count),
		.pending         (pending)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Abort when nothing moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	// Present one request after a random gap (none when no_gaps is set) and hold it until accepted
	task automatic send_request(input logic act, input logic [RANDOM_BITS-1:0] frac);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start           <= 1'b1;
		action          <= act;
		random_fraction <= frac;
		do
			@(posedge clk);
		while (busy);
		@(negedge clk);
		requests_sent++;
	endtask

	// Drop start and wait until every result is back
	task automatic drain();
		start <= 1'b0;
		do
			@(negedge clk);
		while (pending != 0 || busy);
	endtask

	// Write one or both registers on idle
	task automatic cfg_write(input bit wr_tokens, input logic [15:0] tokens,
			input bit wr_entries, input logic [15:0] entries_word);
		if (wr_tokens) begin
			cfg_we    <= 1'b1;
			cfg_index <= REG_TOKENS;
			cfg_wdata <= tokens;
			@(negedge clk);
		end
		if (wr_entries) begin
			cfg_we    <= 1'b1;
			cfg_index <= REG_ENTRIES;
			cfg_wdata <= entries_word;
			@(negedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	function automatic logic [RANDOM_BITS-1:0] pick_fraction();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			default: return RANDOM_BITS'($urandom_range(0, 65535));
		endcase
	endfunction

	initial begin
		logic [15:0] tokens;
		logic [6:0]  entries;
		int          mode;
		int          n_draws;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Draw on the empty table after reset
		send_request(ACT_DRAW, pick_fraction());
		// Default registers: ends of the fraction range and an immediate repeat
		send_request(ACT_RESTART, RANDOM_BITS'($urandom_range(0, 65535)));
		send_request(ACT_DRAW, 16'h0000);
		send_request(ACT_DRAW, 16'h0000);
		send_request(ACT_DRAW, 16'hFFFF);
		send_request(ACT_DRAW, 16'h8000);
		send_request(ACT_DRAW, 16'h0000);
		// Zero tokens: restart reports exhausted
		drain();
		cfg_write(1'b1, 16'h0000, 1'b0, 16'h0000);
		send_request(ACT_RESTART, 16'hFFFF);
		send_request(ACT_DRAW, 16'hFFFF);
		// No entries in use
		drain();
		cfg_write(1'b1, 16'd5, 1'b1, 16'h0000);
		send_request(ACT_RESTART, 16'h0000);
		send_request(ACT_DRAW, 16'h1234);
		// Entry count above the table size, full token count
		drain();
		cfg_write(1'b1, 16'hFFFF, 1'b1, 16'hFFFF);
		send_request(ACT_RESTART, 16'hAAAA);
		send_request(ACT_DRAW, 16'hFFFF);
		send_request(ACT_DRAW, 16'h0000);
		send_request(ACT_DRAW, 16'h0000);
		// Only the previous pick keeps tokens: every later draw is rejected
		drain();
		cfg_write(1'b1, 16'd2, 1'b1, 16'd1);
		send_request(ACT_RESTART, 16'h5555);
		send_request(ACT_DRAW, pick_fraction());
		send_request(ACT_DRAW, pick_fraction());
		send_request(ACT_DRAW, pick_fraction());
		// Run the table dry
		drain();
		cfg_write(1'b1, 16'd1, 1'b1, 16'd2);
		send_request(ACT_RESTART, 16'h0F0F);
		send_request(ACT_DRAW, 16'h0000);
		send_request(ACT_DRAW, 16'hFFFF);
		send_request(ACT_DRAW, 16'h7FFF);
		// A register change waits for the next restart
		drain();
		cfg_write(1'b1, 16'd3, 1'b1, 16'd64);
		send_request(ACT_DRAW, 16'h4000);
		send_request(ACT_RESTART, 16'hF0F0);
		send_request(ACT_DRAW, 16'h4000);

		// Random phases: new settings, a restart, then a run of draws with an occasional restart
		while (requests_sent < RAND_ITEMS + 26) begin
			drain();
			case ($urandom_range(0, 5))
				0:       tokens = 16'd0;
				1:       tokens = 16'd1;
				2:       tokens = 16'($urandom_range(2, 4));
				3:       tokens = 16'hFFFF;
				4:       tokens = 16'($urandom_range(0, 65535));
				default: tokens = 16'($urandom_range(1, 20));
			endcase
			case ($urandom_range(0, 5))
				0:       entries = 7'd0;
				1:       entries = 7'd1;
				2:       entries = 7'($urandom_range(2, 6));
				3:       entries = 7'd64;
				4:       entries = 7'($urandom_range(65, 127));
				default: entries = 7'($urandom_range(1, 64));
			endcase
			mode = $urandom_range(0, 3);
			cfg_write(mode != 1, tokens, mode != 0,
				{9'($urandom_range(0, 511)), entries});
			no_gaps = ($urandom_range(0, 3) == 0);
			send_request(ACT_RESTART, RANDOM_BITS'($urandom_range(0, 65535)));
			n_draws = $urandom_range(8, 40);
			for (int i = 0; i < n_draws; i++) begin
				if ($urandom_range(0, 19) == 0)
					send_request(ACT_RESTART, RANDOM_BITS'($urandom_range(0, 65535)));
				else
					send_request(ACT_DRAW, pick_fraction());
			end
		end

		drain();
		repeat (END_LATENCY) @(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// File: files.f
hw/rtl/wdr_pkg.sv
hw/rtl/wdr_count_mem.sv
hw/rtl/weighted_draw_without_repeat.sv
dv/weighted_draw_checker.sv
dv/weighted_draw_without_repeat_tb.sv
